// ----- sv/keypad_pin_lock_with_lockout_core_assert.svh -----
// assertion macros shared by the keypad lock rtl
`ifndef KEYPAD_PIN_LOCK_WITH_LOCKOUT_CORE_ASSERT_SVH
`define KEYPAD_PIN_LOCK_WITH_LOCKOUT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define KPL_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("keypad lock assertion failed");
// next-cycle implication, checked outside reset
`define KPL_ASSERT_NXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("keypad lock assertion failed");
`else
`define KPL_ASSERT_IMP(label, clock, resetn, ante, cons)
`define KPL_ASSERT_NXT(label, clock, resetn, ante, cons)
`endif
`endif

// ----- sv/kpl_pkg.sv -----
package kpl_pkg;

    localparam int PIN_DIGITS = 4;
    localparam int DIGIT_W    = 4;
    localparam int ENTRY_W    = DIGIT_W * PIN_DIGITS;
    localparam int COUNT_W    = 3;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int FAIL_W     = 4;
    localparam int TICKS_W    = 22;
    localparam int SECS_W     = 13;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(PIN_DIGITS);
    localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 4'd9;
    localparam logic [FAIL_W-1:0]  FAIL_MAX   = 4'd15;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_DIGIT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LOCK_MODE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STORED_PIN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_TICKS = 2'd3;

    localparam logic [FAIL_W-1:0]  RST_ATTEMPT_LIMIT = 4'd5;
    localparam logic [TICKS_W-1:0] RST_LOCKOUT_TICKS = 22'd60000;

    // ticks / 1000 = (ticks >> 3) / 125, done as multiply by ceil(2^26 / 125)
    localparam int RECIP_W   = 20;
    localparam int SEC_SHIFT = 26;
    localparam logic [RECIP_W-1:0] SEC_RECIP = 20'd536871;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE        = 3'd0,
        ST_LOCKED      = 3'd1,
        ST_AUTH_OK     = 3'd2,
        ST_AUTH_FAIL   = 3'd3,
        ST_FAIL_LOCKED = 3'd4,
        ST_FIRST_HELD  = 3'd5,
        ST_PIN_CHANGED = 3'd6,
        ST_MISMATCH    = 3'd7
    } status_t;

    typedef struct packed {
        logic                lock_mode;
        logic [ENTRY_W-1:0]  stored_pin;
        logic [FAIL_W-1:0]   attempt_limit;
        logic [TICKS_W-1:0]  lockout_ticks;
    } kpl_cfg_t;

    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  digits_shown;
        logic [FAIL_W-1:0]   attempts_left;
        logic [SECS_W-1:0]   lock_seconds;
        logic [ENTRY_W-1:0]  new_pin;
    } kpl_res_t;

    function automatic logic [SECS_W-1:0] secs_of_ticks(input logic [TICKS_W-1:0] ticks);
        logic [TICKS_W-4:0]           eighths;
        logic [TICKS_W-3+RECIP_W-1:0] prod;
        eighths = ticks[TICKS_W-1:3];
        prod    = eighths * SEC_RECIP;
        return prod[SEC_SHIFT+SECS_W-1:SEC_SHIFT];
    endfunction

endpackage

// ----- sv/kpl_in_if.sv -----
interface kpl_in_if;
    logic                          valid;
    logic                          ready;
    logic [kpl_pkg::KIND_W-1:0]    kind;
    logic [kpl_pkg::DIGIT_W-1:0]   key_digit;

    modport source (output valid, output kind, output key_digit, input ready);
    modport sink (input valid, input kind, input key_digit, output ready);
endinterface

// ----- sv/kpl_out_if.sv -----
interface kpl_out_if;
    logic                          valid;
    logic                          ready;
    logic [kpl_pkg::STATUS_W-1:0]  status;
    logic [kpl_pkg::COUNT_W-1:0]   digits_shown;
    logic [kpl_pkg::FAIL_W-1:0]    attempts_left;
    logic [kpl_pkg::SECS_W-1:0]    lock_seconds;
    logic [kpl_pkg::ENTRY_W-1:0]   new_pin;

    modport source (output valid, output status, output digits_shown, output attempts_left,
                    output lock_seconds, output new_pin, input ready);
    modport sink (input valid, input status, input digits_shown, input attempts_left,
                  input lock_seconds, input new_pin, output ready);
endinterface

// ----- sv/keypad_pin_lock_with_lockout_core.sv -----
// keypad pin lock with failure lockout
// in_ch carries one keypad item per handshake: kind (digit, delete, clear,
// millisecond tick, cancel) and key_digit. out_ch returns exactly one result
// item per input item, in order: status, digits_shown, attempts_left,
// lock_seconds and new_pin.
// an accepted item is held in the input register, then the whole step
// (gate, entry update, compare, counters, seconds via reciprocal multiply) is
// evaluated and written to the result register: each item passes the input
// register and then the result register before out_ch.valid rises. one item
// per cycle is sustained while out_ch.ready stays high; the seconds
// multiplier in front of the result register sets the cycle time.
// when out_ch.ready is low the result register holds, the input register
// still takes one more item, and in_ch.ready drops once both are full.
// the apb port holds lock_mode, stored_pin, attempt_limit and lockout_ticks at
// byte addresses 0, 4, 8 and 12; write registers only while no item is in
// flight. writing lock_mode also drops the current entry and any pending setup.
// rst_n (async, active low) empties both stages, clears entry, setup state,
// failure count and lockout, and loads the register defaults (limit 5,
// lockout 60000 ticks).
module keypad_pin_lock_with_lockout_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    kpl_in_if.sink                        in_ch,
    kpl_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpl_pkg::ADDR_W-1:0]    paddr,
    input  logic [kpl_pkg::DATA_W-1:0]    pwdata,
    output logic [kpl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    `include "keypad_pin_lock_with_lockout_core_assert.svh"

    kpl_pkg::kpl_cfg_t cfg;
    logic              mode_restart;

    kpl_apb_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cfg          (cfg),
        .mode_restart (mode_restart)
    );

    // input stage
    logic                           in_valid_reg, in_valid_next;
    logic [kpl_pkg::KIND_W-1:0]     kind_reg;
    logic [kpl_pkg::DIGIT_W-1:0]    digit_reg;
    // result stage
    logic                           out_valid_reg, out_valid_next;
    kpl_pkg::kpl_res_t              res_reg;
    // lock state
    logic [kpl_pkg::ENTRY_W-1:0]    entry_reg, entry_next;
    logic [kpl_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [kpl_pkg::ENTRY_W-1:0]    first_reg, first_next;
    logic                           pend_reg, pend_next;
    logic [kpl_pkg::FAIL_W-1:0]     fail_reg, fail_next;
    logic [kpl_pkg::TICKS_W-1:0]    lock_reg, lock_next;

    logic                           advance, take, load;
    kpl_pkg::kpl_res_t              res;
    kpl_pkg::status_t               st;
    logic [kpl_pkg::FAIL_W-1:0]     left;
    logic [kpl_pkg::ENTRY_W-1:0]    npin;
    logic [kpl_pkg::TICKS_W-1:0]    div_in;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;
    assign load        = in_valid_reg && advance;

    // one keypad step
    always_comb
    begin
        logic                        blocked;
        logic [kpl_pkg::ENTRY_W-1:0] ent;
        logic [kpl_pkg::COUNT_W-1:0] cnt;
        logic [kpl_pkg::FAIL_W-1:0]  fc;
        st         = kpl_pkg::ST_NONE;
        left       = '0;
        npin       = '0;
        blocked    = 1'b0;
        ent        = entry_reg;
        cnt        = count_reg;
        fc         = fail_reg;
        entry_next = entry_reg;
        count_next = count_reg;
        first_next = first_reg;
        pend_next  = pend_reg;
        fail_next  = fail_reg;
        lock_next  = lock_reg;
        if (load)
        begin
            if (kind_reg == kpl_pkg::KIND_TICK)
            begin
                if (lock_reg != '0)
                begin
                    lock_next = lock_reg - 1'b1;
                end
            end
            else if (kind_reg == kpl_pkg::KIND_CANCEL)
            begin
                entry_next = '0;
                count_next = '0;
                first_next = '0;
                pend_next  = 1'b0;
            end
            else if (kind_reg == kpl_pkg::KIND_DIGIT || kind_reg == kpl_pkg::KIND_DELETE
                     || kind_reg == kpl_pkg::KIND_CLEAR)
            begin
                // lockout gate, authenticate mode only
                if (!cfg.lock_mode && fail_reg >= cfg.attempt_limit)
                begin
                    if (lock_reg != '0)
                    begin
                        blocked = 1'b1;
                        st      = kpl_pkg::ST_LOCKED;
                    end
                    else
                    begin
                        fc = '0;
                    end
                end
                if (!blocked)
                begin
                    if (kind_reg == kpl_pkg::KIND_DELETE)
                    begin
                        if (cnt != '0)
                        begin
                            ent = {{kpl_pkg::DIGIT_W{1'b0}},
                                   ent[kpl_pkg::ENTRY_W-1:kpl_pkg::DIGIT_W]};
                            cnt = cnt - 1'b1;
                        end
                    end
                    else if (kind_reg == kpl_pkg::KIND_CLEAR)
                    begin
                        ent = '0;
                        cnt = '0;
                    end
                    else if (digit_reg <= kpl_pkg::MAX_DIGIT && cnt < kpl_pkg::FULL_COUNT)
                    begin
                        ent = {ent[kpl_pkg::ENTRY_W-kpl_pkg::DIGIT_W-1:0], digit_reg};
                        cnt = cnt + 1'b1;
                    end

                    // auto submit on the last digit
                    if (cnt == kpl_pkg::FULL_COUNT)
                    begin
                        entry_next = '0;
                        count_next = '0;
                        if (!cfg.lock_mode)
                        begin
                            if (ent == cfg.stored_pin)
                            begin
                                fc = '0;
                                st = kpl_pkg::ST_AUTH_OK;
                            end
                            else
                            begin
                                if (fc < kpl_pkg::FAIL_MAX)
                                begin
                                    fc = fc + 1'b1;
                                end
                                if (fc >= cfg.attempt_limit)
                                begin
                                    lock_next = cfg.lockout_ticks;
                                    st        = kpl_pkg::ST_FAIL_LOCKED;
                                end
                                else
                                begin
                                    st   = kpl_pkg::ST_AUTH_FAIL;
                                    left = cfg.attempt_limit - fc;
                                end
                            end
                        end
                        else if (!pend_reg)
                        begin
                            first_next = ent;
                            pend_next  = 1'b1;
                            st         = kpl_pkg::ST_FIRST_HELD;
                        end
                        else
                        begin
                            if (ent == first_reg)
                            begin
                                st   = kpl_pkg::ST_PIN_CHANGED;
                                npin = ent;
                            end
                            else
                            begin
                                st = kpl_pkg::ST_MISMATCH;
                            end
                            first_next = '0;
                            pend_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        entry_next = ent;
                        count_next = cnt;
                    end
                end
                fail_next = fc;
            end
        end
        // lock_mode write while idle drops the entry and setup
        if (mode_restart)
        begin
            entry_next = '0;
            count_next = '0;
            first_next = '0;
            pend_next  = 1'b0;
        end
    end

    // seconds left: live countdown when blocked, full lockout when just locked
    assign div_in = (st == kpl_pkg::ST_LOCKED) ? lock_reg : cfg.lockout_ticks;

    always_comb
    begin
        res.status        = st;
        res.digits_shown  = count_next;
        res.attempts_left = left;
        res.new_pin       = npin;
        case (st) inside
            kpl_pkg::ST_LOCKED, kpl_pkg::ST_FAIL_LOCKED:
                res.lock_seconds = kpl_pkg::secs_of_ticks(div_in);
            default:
                res.lock_seconds = '0;
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            entry_reg     <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            pend_reg      <= 1'b0;
            fail_reg      <= '0;
            lock_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            entry_reg     <= entry_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            pend_reg      <= pend_next;
            fail_reg      <= fail_next;
            lock_reg      <= lock_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= in_ch.kind;
            digit_reg <= in_ch.key_digit;
        end
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = res_reg.status;
    assign out_ch.digits_shown  = res_reg.digits_shown;
    assign out_ch.attempts_left = res_reg.attempts_left;
    assign out_ch.lock_seconds  = res_reg.lock_seconds;
    assign out_ch.new_pin       = res_reg.new_pin;

    `KPL_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= kpl_pkg::FULL_COUNT)
    `KPL_ASSERT_NXT(a_hold_input, clk, rst_n, in_valid_reg && !advance,
                    in_valid_reg && $stable(kind_reg) && $stable(digit_reg))
    `KPL_ASSERT_NXT(a_ok_clears_fail, clk, rst_n, load && st == kpl_pkg::ST_AUTH_OK,
                    fail_reg == '0)
    `KPL_ASSERT_NXT(a_lock_loaded, clk, rst_n, load && st == kpl_pkg::ST_FAIL_LOCKED,
                    lock_reg == $past(cfg.lockout_ticks))
    `KPL_ASSERT_IMP(a_pin_only_on_change, clk, rst_n,
                    out_valid_reg && res_reg.status != kpl_pkg::ST_PIN_CHANGED,
                    res_reg.new_pin == '0)

endmodule

// ----- sv/kpl_apb_regs.sv -----
module kpl_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpl_pkg::ADDR_W-1:0]    paddr,
    input  logic [kpl_pkg::DATA_W-1:0]    pwdata,
    output logic [kpl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output kpl_pkg::kpl_cfg_t             cfg,
    output logic                          mode_restart
);

    kpl_pkg::kpl_cfg_t cfg_reg;
    kpl_pkg::kpl_cfg_t cfg_next;
    logic              wr_en;
    logic [kpl_pkg::REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[kpl_pkg::ADDR_W-1:2];

    always_comb
    begin
        cfg_next     = cfg_reg;
        mode_restart = 1'b0;
        if (wr_en)
        begin
            unique case (idx)
                kpl_pkg::REG_LOCK_MODE:
                begin
                    cfg_next.lock_mode = pwdata[0];
                    mode_restart       = 1'b1;
                end
                kpl_pkg::REG_STORED_PIN:
                    cfg_next.stored_pin = pwdata[kpl_pkg::ENTRY_W-1:0];
                kpl_pkg::REG_ATTEMPT_LIMIT:
                    cfg_next.attempt_limit = pwdata[kpl_pkg::FAIL_W-1:0];
                kpl_pkg::REG_LOCKOUT_TICKS:
                    cfg_next.lockout_ticks = pwdata[kpl_pkg::TICKS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            kpl_pkg::REG_LOCK_MODE:
                prdata = kpl_pkg::DATA_W'(cfg_reg.lock_mode);
            kpl_pkg::REG_STORED_PIN:
                prdata = kpl_pkg::DATA_W'(cfg_reg.stored_pin);
            kpl_pkg::REG_ATTEMPT_LIMIT:
                prdata = kpl_pkg::DATA_W'(cfg_reg.attempt_limit);
            kpl_pkg::REG_LOCKOUT_TICKS:
                prdata = kpl_pkg::DATA_W'(cfg_reg.lockout_ticks);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_mode     <= 1'b0;
            cfg_reg.stored_pin    <= '0;
            cfg_reg.attempt_limit <= kpl_pkg::RST_ATTEMPT_LIMIT;
            cfg_reg.lockout_ticks <= kpl_pkg::RST_LOCKOUT_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
